@@ rtl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared sizes, codes and controller/datapath interface types for the
// first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	// Number of storage blocks tracked by the free map.
	localparam int NUM_BLOCKS = 32;

	// Widths of a block index and of a run length up to NUM_BLOCKS.
	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	// Fixed field widths of the request and result items.
	localparam int OP_W    = 1;
	localparam int BCNT_W  = 6;
	localparam int SBLK_W  = 5;
	localparam int STAT_W  = 2;
	localparam int RSTRT_W = 5;

	// Width wide enough to compare a run length against a request count,
	// and one more bit for start plus count.
	localparam int CMP_W = (CNT_W > BCNT_W) ? CNT_W : BCNT_W;
	localparam int SUM_W = CMP_W + 1;

	// Request operation codes.
	localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
	localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD     = 2'd2;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_UPDATE,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the request and reset scan state
		logic scan;        // examine one block of the free map
		logic update;      // write the selected range of the free map
		logic set_bad;     // record a bad-request status
		logic set_nospace; // record a no-space status
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic zero_cnt;    // requested count is zero
		logic is_release;  // request is a release
		logic range_bad;   // release range runs past the last block
		logic hit;         // current scan step completes a long enough run
		logic scan_last;   // current scan step is at the last block
	} dp_stat_t;

endpackage

@@ rtl/ffba_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencing state machine: decodes a request, steps the first-fit scan,
// commits the map update and presents the result for one cycle.
// ----------------------------------------------------------------------------
module ffba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ffba_pkg::dp_stat_t dp_stat,
	output ffba_pkg::dp_cmd_t  dp_cmd,
	output logic               busy,
	output logic               done
);
	import ffba_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (dp_stat.zero_cnt) begin
					state_nxt = S_RESP;
				end else if (dp_stat.is_release) begin
					state_nxt = dp_stat.range_bad ? S_RESP : S_UPDATE;
				end else begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (dp_stat.hit) begin
					state_nxt = S_UPDATE;
				end else if (dp_stat.scan_last) begin
					state_nxt = S_RESP;
				end
			end
			S_UPDATE: begin
				state_nxt = S_RESP;
			end
			S_RESP: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Output and command logic.
	always_comb begin
		dp_cmd = '0;
		busy   = 1'b1;
		done   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				dp_cmd.load = start;
			end
			S_DECODE: begin
				dp_cmd.set_bad = dp_stat.zero_cnt ||
					(dp_stat.is_release && dp_stat.range_bad);
			end
			S_SCAN: begin
				dp_cmd.scan        = 1'b1;
				dp_cmd.set_nospace = !dp_stat.hit && dp_stat.scan_last;
			end
			S_UPDATE: begin
				dp_cmd.update = 1'b1;
			end
			S_RESP: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

@@ rtl/ffba_dpath.sv @@
// ----------------------------------------------------------------------------
// ffba_dpath
// Free map, request registers, scan index and run counter, and the result
// registers of the allocator.
// ----------------------------------------------------------------------------
module ffba_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ffba_pkg::dp_cmd_t                    dp_cmd,
	input  logic [ffba_pkg::OP_W-1:0]            opcode,
	input  logic [ffba_pkg::BCNT_W-1:0]          block_count,
	input  logic [ffba_pkg::SBLK_W-1:0]          start_block,
	output ffba_pkg::dp_stat_t                   dp_stat,
	output logic [ffba_pkg::STAT_W-1:0]          status,
	output logic [ffba_pkg::RSTRT_W-1:0]         run_start
);
	import ffba_pkg::*;

	logic [NUM_BLOCKS-1:0] free_q;
	logic [OP_W-1:0]       op_q;
	logic [BCNT_W-1:0]     count_q;
	logic [SBLK_W-1:0]     sblk_q;
	logic [IDX_W-1:0]      idx_q;
	logic [CNT_W-1:0]      run_q;
	logic [IDX_W-1:0]      base_q;
	logic [IDX_W-1:0]      found_q;
	logic [STAT_W-1:0]     stat_q;

	logic [CNT_W-1:0]      run_nxt;
	logic [CMP_W-1:0]      found_wide;
	logic [SUM_W-1:0]      rel_end;
	logic [SUM_W-1:0]      upd_end;
	logic                  upd_val;

	// One scan step: extend or restart the current free run.
	always_comb begin
		run_nxt    = free_q[idx_q] ? (run_q + CNT_W'(1)) : '0;
		found_wide = CMP_W'(idx_q) + CMP_W'(1) - CMP_W'(count_q);
		rel_end    = SUM_W'(sblk_q) + SUM_W'(count_q);
		upd_end    = SUM_W'(base_q) + SUM_W'(count_q);
		upd_val    = (op_q == OP_RELEASE);
	end

	// Status toward the controller.
	always_comb begin
		dp_stat.zero_cnt   = (count_q == '0);
		dp_stat.is_release = (op_q == OP_RELEASE);
		dp_stat.range_bad  = (rel_end > SUM_W'(NUM_BLOCKS));
		dp_stat.hit        = free_q[idx_q] && (CMP_W'(run_nxt) == CMP_W'(count_q));
		dp_stat.scan_last  = (idx_q == IDX_W'(NUM_BLOCKS - 1));
	end

	// Request registers, scan state and result registers.
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			op_q    <= opcode;
			count_q <= block_count;
			sblk_q  <= start_block;
			base_q  <= IDX_W'(start_block);
			idx_q   <= '0;
			run_q   <= '0;
			found_q <= '0;
			stat_q  <= ST_OK;
		end else begin
			if (dp_cmd.scan) begin
				run_q <= run_nxt;
				if (!dp_stat.scan_last) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (dp_stat.hit) begin
					found_q <= IDX_W'(found_wide);
					base_q  <= IDX_W'(found_wide);
				end
			end
			if (dp_cmd.set_bad) begin
				stat_q <= ST_BAD;
			end
			if (dp_cmd.set_nospace) begin
				stat_q <= ST_NOSPACE;
			end
		end
	end

	// Free map: every block free after reset; a range is written in a single
	// update, each block comparing its own index against the range bounds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else if (dp_cmd.update) begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				if ((SUM_W'(i) >= SUM_W'(base_q)) && (SUM_W'(i) < upd_end)) begin
					free_q[i] <= upd_val;
				end
			end
		end
	end

	// Result fields; run_start is zero unless an allocate succeeded.
	assign status    = stat_q;
	assign run_start = ((stat_q == ST_OK) && (op_q == OP_ALLOC)) ?
		RSTRT_W'(found_q) : '0;

endmodule

@@ rtl/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Keeps a free map of fixed storage blocks and serves first-fit allocate
// and release requests for contiguous runs of blocks.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  --------  --------------------  ----------------------------------------
//  request   start & !busy         opcode, block_count, start_block
//  result    done (one cycle)      status, run_start
//
// One item is in work at a time; busy stays high from the accept edge until
// the result cycle has ended. An allocate that finds a run passes through
// decode, the first-fit scan, the map update and the result state; the scan
// visits at most NUM_BLOCKS blocks, one block per cycle. An allocate that
// finds no run visits every block, skips the map write and goes straight to
// the result. A release goes from decode to the map update and the result;
// a bad request goes from decode to the result. Reset marks every block free
// at once. The result is shown for exactly one cycle and cannot be stalled.
//
module first_fit_block_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ffba_pkg::OP_W-1:0]     opcode,
	input  logic [ffba_pkg::BCNT_W-1:0]   block_count,
	input  logic [ffba_pkg::SBLK_W-1:0]   start_block,
	output logic                          done,
	output logic [ffba_pkg::STAT_W-1:0]   status,
	output logic [ffba_pkg::RSTRT_W-1:0]  run_start
);
	import ffba_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// Sequencer.
	ffba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.dp_stat (dp_stat),
		.dp_cmd  (dp_cmd),
		.busy    (busy),
		.done    (done)
	);

	// Free map and scan datapath.
	ffba_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.opcode      (opcode),
		.block_count (block_count),
		.start_block (start_block),
		.dp_stat     (dp_stat),
		.status      (status),
		.run_start   (run_start)
	);

endmodule
